### design/assert_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, disabled while arst_n is low.
`define PLD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define PLD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/pld_pkg.sv
// Shared constants and types for the polyline stream decoder.
package pld_pkg;

	localparam logic [7:0] CHAR_OFFSET = 8'd63;
	localparam logic [7:0] CONT_THRESH = 8'd95;   // offset plus the continue bit 0x20
	localparam logic [2:0] MAX_CHUNK_IDX = 3'd6;  // chunk placed at shift 30 closes the value
	localparam logic [4:0] CHUNK_BITS = 5'd5;

	localparam logic signed [28:0] BOUND_LOW_INIT = 29'sd1800000;
	localparam logic signed [28:0] BOUND_HIGH_INIT = -29'sd1800000;

	// floor(m / 10) == (m * RECIP_TEN) >> RECIP_SHIFT for every 32-bit m
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [31:0] dlat;
		logic [31:0] dlng;
		logic        coord;  // pair carries a coordinate (not the dropped all-zero tail)
		logic        last;   // pair closes the string
	} pld_op_t;

endpackage

### design/pld_front.sv
// Front end: chunk assembly, value closing and lat/lng pairing.
module pld_front import pld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       feed_valid,
	output logic       feed_ready,
	input  logic [7:0] char_byte,
	input  logic       last_byte,
	input  logic       q_full,
	output logic       push,
	output pld_op_t    push_op
);
`include "assert_macros.svh"

	logic [31:0] accum_q;
	logic [2:0]  idx_q;
	logic        in_lng_q;
	logic [31:0] held_q;

	logic        fire;
	logic [4:0]  chunk;
	logic        cont;
	logic [4:0]  shamt;
	logic [31:0] acc;
	logic        closes;
	logic [31:0] half;
	logic [31:0] val;
	logic [31:0] dlat;
	logic [31:0] dlng;

	assign feed_ready = !q_full;
	assign fire = feed_valid && feed_ready;

	always_comb begin
		chunk = 5'(char_byte - CHAR_OFFSET);
		cont = char_byte >= CONT_THRESH;
		shamt = 5'(idx_q) * CHUNK_BITS;
		acc = accum_q | (32'(chunk) << shamt);
		closes = !cont || (idx_q == MAX_CHUNK_IDX) || last_byte;
		half = {acc[31], acc[31:1]};
		val = acc[0] ? ~half : half;
		dlat = in_lng_q ? held_q : val;
		dlng = in_lng_q ? val : '0;
	end

	// a pair leaves on a longitude close, or on the last beat with whatever is pending
	assign push = fire && closes && (in_lng_q || last_byte);
	assign push_op.dlat = dlat;
	assign push_op.dlng = dlng;
	assign push_op.coord = !(last_byte && (dlat == '0) && (dlng == '0));
	assign push_op.last = last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			idx_q <= '0;
			in_lng_q <= 1'b0;
		end else if (fire) begin
			if (closes) begin
				accum_q <= '0;
				idx_q <= '0;
				in_lng_q <= !in_lng_q && !last_byte;
			end else begin
				accum_q <= acc;
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && closes && !in_lng_q) begin
			held_q <= val;
		end
	end

	`PLD_ASSERT(a_last_clears, (fire && last_byte) |=> (!in_lng_q && idx_q == '0 && accum_q == '0), "front state not cleared after last beat")
	`PLD_ASSERT(a_idx_range, (idx_q <= MAX_CHUNK_IDX), "chunk index past shift cap")

endmodule

### design/pld_queue.sv
// Short pair queue between front and back ends.
module pld_queue import pld_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  pld_op_t push_op,
	input  logic    pop,
	output logic    full,
	output logic    empty,
	output pld_op_t head
);
`include "assert_macros.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pld_op_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full = count_q == CNT_FULL;
	assign empty = count_q == '0;
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`PLD_ASSERT(a_no_overflow, push |-> !full, "push into full queue")

endmodule

### design/pld_back.sv
// Back end: running sums, divide by ten, bounds and result register.
module pld_back import pld_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  pld_op_t             head,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_ready,
	output logic                coord_valid,
	output logic signed [28:0]  lat_out,
	output logic signed [28:0]  lng_out,
	output logic signed [28:0]  min_lat,
	output logic signed [28:0]  max_lat,
	output logic signed [28:0]  min_lng,
	output logic signed [28:0]  max_lng,
	output logic                end_of_string
);
`include "assert_macros.svh"

	logic adv;

	logic [31:0] lat_sum_q, lng_sum_q;
	logic signed [28:0] lat_low_q, lat_high_q, lng_low_q, lng_high_q;

	logic        v_s1, v_s2, v_s3;
	logic [31:0] lat_s1, lng_s1;
	logic        coord_s1, last_s1;
	logic [31:0] lat_mag_s2, lng_mag_s2;
	logic        lat_neg_s2, lng_neg_s2, coord_s2, last_s2;
	logic [28:0] lat_quot_s3, lng_quot_s3;
	logic        lat_neg_s3, lng_neg_s3, coord_s3, last_s3;

	logic [31:0] lat_next, lng_next;
	logic [63:0] lat_prod, lng_prod;
	logic signed [28:0] lat_val, lng_val;
	logic signed [28:0] lat_lo_n, lat_hi_n, lng_lo_n, lng_hi_n;

	// whole back pipeline moves when the result register can take a beat
	assign adv = !result_valid || result_ready;
	assign pop = adv && !q_empty;

	assign lat_next = lat_sum_q + head.dlat;
	assign lng_next = lng_sum_q + head.dlng;

	assign lat_prod = lat_mag_s2 * RECIP_TEN;
	assign lng_prod = lng_mag_s2 * RECIP_TEN;

	always_comb begin
		lat_val = lat_neg_s3 ? -$signed(lat_quot_s3) : $signed(lat_quot_s3);
		lng_val = lng_neg_s3 ? -$signed(lng_quot_s3) : $signed(lng_quot_s3);
		lat_lo_n = lat_low_q;
		lat_hi_n = lat_high_q;
		lng_lo_n = lng_low_q;
		lng_hi_n = lng_high_q;
		if (coord_s3) begin
			if (lat_val < lat_low_q)  lat_lo_n = lat_val;
			if (lat_val > lat_high_q) lat_hi_n = lat_val;
			if (lng_val < lng_low_q)  lng_lo_n = lng_val;
			if (lng_val > lng_high_q) lng_hi_n = lng_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_sum_q <= '0;
			lng_sum_q <= '0;
			lat_low_q <= BOUND_LOW_INIT;
			lat_high_q <= BOUND_HIGH_INIT;
			lng_low_q <= BOUND_LOW_INIT;
			lng_high_q <= BOUND_HIGH_INIT;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					lat_sum_q <= '0;
					lng_sum_q <= '0;
				end else if (head.coord) begin
					lat_sum_q <= lat_next;
					lng_sum_q <= lng_next;
				end
			end
			if (adv) begin
				v_s1 <= pop;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				result_valid <= v_s3;
				if (v_s3) begin
					if (last_s3) begin
						lat_low_q <= BOUND_LOW_INIT;
						lat_high_q <= BOUND_HIGH_INIT;
						lng_low_q <= BOUND_LOW_INIT;
						lng_high_q <= BOUND_HIGH_INIT;
					end else begin
						lat_low_q <= lat_lo_n;
						lat_high_q <= lat_hi_n;
						lng_low_q <= lng_lo_n;
						lng_high_q <= lng_hi_n;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lat_s1 <= lat_next;
			lng_s1 <= lng_next;
			coord_s1 <= head.coord;
			last_s1 <= head.last;

			lat_neg_s2 <= lat_s1[31];
			lng_neg_s2 <= lng_s1[31];
			lat_mag_s2 <= lat_s1[31] ? 32'(0 - lat_s1) : lat_s1;
			lng_mag_s2 <= lng_s1[31] ? 32'(0 - lng_s1) : lng_s1;
			coord_s2 <= coord_s1;
			last_s2 <= last_s1;

			lat_quot_s3 <= lat_prod[63:RECIP_SHIFT];
			lng_quot_s3 <= lng_prod[63:RECIP_SHIFT];
			lat_neg_s3 <= lat_neg_s2;
			lng_neg_s3 <= lng_neg_s2;
			coord_s3 <= coord_s2;
			last_s3 <= last_s2;

			coord_valid <= coord_s3;
			lat_out <= coord_s3 ? lat_val : '0;
			lng_out <= coord_s3 ? lng_val : '0;
			min_lat <= lat_lo_n;
			max_lat <= lat_hi_n;
			min_lng <= lng_lo_n;
			max_lng <= lng_hi_n;
			end_of_string <= last_s3;
		end
	end

	`PLD_ASSERT(a_drop_is_final, (result_valid && !coord_valid) |-> (end_of_string && lat_out == '0 && lng_out == '0), "dropped pair not a clean final beat")
	`PLD_ASSERT(a_bounds_reset, (adv && v_s3 && last_s3) |=> (lat_low_q == BOUND_LOW_INIT && lng_high_q == BOUND_HIGH_INIT), "bounds not reset after end of string")
	`PLD_ASSERT(a_bounds_order, (result_valid && coord_valid) |-> (min_lat <= max_lat && min_lng <= max_lng), "bounds out of order on a coordinate beat")

endmodule

### design/polyline_stream_decoder_top.sv
// Throughput: one character per cycle unless the queue is full; the front closes at most one
// value per beat, and the back pipeline (sum add, magnitude, reciprocal multiply, bounds) takes
// one pair per cycle unless stalled. Pairs pass the pair queue, stages s1 to s3 and the result
// register; the queue lets the front keep taking characters while the result port stalls.
// Reset: arst_n clears sums, bounds, queue and pipeline valids; a last beat restarts the string.
module polyline_stream_decoder_top import pld_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               feed_valid,
	output logic               feed_ready,
	input  logic [7:0]         char_byte,
	input  logic               last_byte,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               coord_valid,
	output logic signed [28:0] lat_out,
	output logic signed [28:0] lng_out,
	output logic signed [28:0] min_lat,
	output logic signed [28:0] max_lat,
	output logic signed [28:0] min_lng,
	output logic signed [28:0] max_lng,
	output logic               end_of_string
);

	logic    q_push, q_pop, q_full, q_empty;
	pld_op_t q_in, q_head;

	pld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed_valid (feed_valid),
		.feed_ready (feed_ready),
		.char_byte  (char_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.push       (q_push),
		.push_op    (q_in)
	);

	pld_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_in),
		.pop     (q_pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (q_head)
	);

	pld_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head          (q_head),
		.pop           (q_pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.coord_valid   (coord_valid),
		.lat_out       (lat_out),
		.lng_out       (lng_out),
		.min_lat       (min_lat),
		.max_lat       (max_lat),
		.min_lng       (min_lng),
		.max_lng       (max_lng),
		.end_of_string (end_of_string)
	);

endmodule
